### rtl/crceng_pkg.sv
// shared types, constants and crc step functions for the reflected crc engine
package crceng_pkg;

    localparam int BYTES_PER_ITEM = 8;
    localparam int DATA_W         = 64;
    localparam int CRC_W          = 64;
    localparam int COUNT_W        = 4;
    // lanes cannot exceed the bytes that the data field carries
    localparam int LANE_COUNT     = (BYTES_PER_ITEM < DATA_W / 8) ? BYTES_PER_ITEM : DATA_W / 8;
    localparam int LANE_IDX_W     = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int CFG_IDX_W      = 1;

    typedef logic [CRC_W-1:0] crc_t;

    localparam crc_t POLY_32 = 64'h0000_0000_EDB8_8320;
    localparam crc_t POLY_64 = 64'hC96C_5795_D787_0F42;
    localparam crc_t MASK_32 = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 1'b0,
        CFG_SEED = 1'b1
    } cfg_idx_t;

    // control that travels with an item from the lane stage to the merge stage
    typedef struct packed {
        logic                valid;
        logic                start;
        logic                wide;
        logic [COUNT_W-1:0]  count;
    } stage_ctrl_t;

    function automatic crc_t width_mask(input logic wide);
        return wide ? '1 : MASK_32;
    endfunction

    // eight reflected shift steps with no data folded in
    function automatic crc_t crc_shift8(input crc_t crc_in, input logic wide);
        crc_t crc;
        crc_t poly;
        crc  = crc_in;
        poly = wide ? POLY_64 : POLY_32;
        for (int b = 0; b < 8; b++) begin
            crc = (crc >> 1) ^ (crc[0] ? poly : '0);
        end
        return crc;
    endfunction

endpackage

### rtl/crc32_crc64_reflected_engine.sv
// top level of the reflected crc-32 / crc-64 engine
// Reflected CRC-32 (0xEDB88320) or CRC-64 (0xC96C5795D7870F42) over a byte
// stream, up to eight bytes per request, first byte in bits 7:0. A request
// with start_message set reloads the running crc from the inverted seed.
// Every request returns the inverted running crc, which may serve as the seed
// to resume the message later; in 32-bit mode the upper half reads zero.
// Throughput is one request per clock while the result side is not stalled
// by m_ready. The byte lanes work on the request while it is offered and
// register at the handshake; the merge stage then combines them with the
// running crc, advancing it by up to eight bytes and folding in the lane
// sums, and registers the result and m_valid. Requests follow back to back.
// The count is clamped to eight. Configuration writes are taken every cycle
// and must only be issued while no request is in flight.
module crc32_crc64_reflected_engine
    import crceng_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data,
    // input requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_message,
    input  logic [DATA_W-1:0]    s_data_bytes,
    input  logic [COUNT_W-1:0]   s_byte_count,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CRC_W-1:0]     m_crc_result
);

    // configuration registers
    logic wide_reg, wide_next;
    crc_t seed_reg, seed_next;

    // lane stage control
    stage_ctrl_t ctrl_reg, ctrl_next;

    logic               out_en;
    logic               s_load;
    logic [COUNT_W-1:0] count_eff;
    logic [7:0]         aligned_byte [LANE_COUNT];
    crc_t               lane_crc [LANE_COUNT];

    assign cfg_ready = 1'b1;

    always_comb begin
        wide_next = wide_reg;
        seed_next = seed_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE: wide_next = cfg_data[0];
                CFG_SEED: seed_next = cfg_data;
                default:  ;
            endcase
        end
    end

    // the result register frees up whenever it is empty or being drained
    assign out_en  = !m_valid || m_ready;
    assign s_ready = !ctrl_reg.valid || out_en;
    assign s_load  = s_valid && s_ready;

    // clamp the count to the number of lanes
    assign count_eff = (s_byte_count > COUNT_W'(LANE_COUNT)) ? COUNT_W'(LANE_COUNT)
                                                              : s_byte_count;

    // right-align the message bytes onto the top lanes; zero bytes ahead of a
    // message leave a zero crc unchanged, so every lane gets a fixed distance
    // to the end of the request
    always_comb begin
        logic [LANE_IDX_W-1:0] src_idx;
        src_idx = '0;
        for (int j = 0; j < LANE_COUNT; j++) begin
            aligned_byte[j] = 8'h00;
            if (j + int'(count_eff) >= LANE_COUNT) begin
                src_idx         = LANE_IDX_W'(j + int'(count_eff) - LANE_COUNT);
                aligned_byte[j] = s_data_bytes[8*src_idx +: 8];
            end
        end
    end

    always_comb begin
        ctrl_next = ctrl_reg;
        if (s_ready) begin
            ctrl_next.valid = s_valid;
        end
        if (s_load) begin
            ctrl_next.start = s_start_message;
            ctrl_next.wide  = wide_reg;
            ctrl_next.count = count_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg       <= 1'b0;
            seed_reg       <= '0;
            ctrl_reg.valid <= 1'b0;
        end else begin
            wide_reg       <= wide_next;
            seed_reg       <= seed_next;
            ctrl_reg.valid <= ctrl_next.valid;
        end
        // payload side of the lane stage control
        ctrl_reg.start <= ctrl_next.start;
        ctrl_reg.wide  <= ctrl_next.wide;
        ctrl_reg.count <= ctrl_next.count;
    end

    // byte lanes, lane j sits LANE_COUNT-1-j bytes from the end
    for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
        crceng_lane u_lane (
            .aclk         (aclk),
            .load         (s_load),
            .wide         (wide_reg),
            .data_byte    (aligned_byte[j]),
            .zero_bytes   (LANE_IDX_W'(LANE_COUNT - 1 - j)),
            .lane_crc_reg (lane_crc[j])
        );
    end

    crceng_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (out_en),
        .ctrl         (ctrl_reg),
        .lane_crc     (lane_crc),
        .seed         (seed_reg),
        .m_valid      (m_valid),
        .m_crc_result (m_crc_result)
    );

endmodule

### rtl/crceng_lane.sv
// one byte lane: crc of a single byte followed by a fixed run of zero bytes
module crceng_lane
    import crceng_pkg::*;
(
    input  logic                  aclk,
    input  logic                  load,
    input  logic                  wide,
    input  logic [7:0]            data_byte,
    input  logic [LANE_IDX_W-1:0] zero_bytes,
    output crc_t                  lane_crc_reg
);

    crc_t lane_crc_next;

    always_comb begin
        lane_crc_next = crc_shift8({{(CRC_W-8){1'b0}}, data_byte}, wide);
        // carry the byte's contribution past the bytes that follow it
        for (int k = 0; k < LANE_COUNT - 1; k++) begin
            if (LANE_IDX_W'(k) < zero_bytes) begin
                lane_crc_next = crc_shift8(lane_crc_next, wide);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lane_crc_reg <= lane_crc_next;
        end
    end

endmodule

### rtl/crceng_merge.sv
// merge stage: advances the running crc and combines the lane contributions
module crceng_merge
    import crceng_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  stage_ctrl_t ctrl,
    input  crc_t        lane_crc [LANE_COUNT],
    input  crc_t        seed,
    output logic        m_valid,
    output crc_t        m_crc_result
);

    crc_t running_crc_reg, running_crc_next;
    crc_t result_reg, result_next;
    logic valid_reg, valid_next;
    logic take;
    crc_t mask;
    crc_t crc_adv;
    crc_t lane_sum;

    assign take = ctrl.valid && advance;

    always_comb begin
        mask    = width_mask(ctrl.wide);
        crc_adv = ctrl.start ? (~seed & mask) : (running_crc_reg & mask);
        for (int k = 0; k < LANE_COUNT; k++) begin
            if (COUNT_W'(k) < ctrl.count) begin
                crc_adv = crc_shift8(crc_adv, ctrl.wide);
            end
        end
        lane_sum = '0;
        for (int j = 0; j < LANE_COUNT; j++) begin
            lane_sum = lane_sum ^ lane_crc[j];
        end
        running_crc_next = take ? ((crc_adv ^ lane_sum) & mask) : running_crc_reg;
        result_next      = take ? (~(crc_adv ^ lane_sum) & mask) : result_reg;
        valid_next       = advance ? ctrl.valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= '1;
            valid_reg       <= 1'b0;
        end else begin
            running_crc_reg <= running_crc_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid      = valid_reg;
    assign m_crc_result = result_reg;

endmodule

### test/crc_checker.sv
// checker for the reflected crc engine: follows config writes, predicts every result and compares
module crc_checker
    import crceng_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_start_message,
    input  logic [DATA_W-1:0]    s_data_bytes,
    input  logic [COUNT_W-1:0]   s_byte_count,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CRC_W-1:0]     m_crc_result,
    output int                   mismatches,
    output int                   crc_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic wide_mode;
    crc_t seed_reg;
    crc_t running_crc;
    crc_t expected_crcs[$];

    // bitwise reflected crc over the low nbytes of data, first byte first
    function automatic crc_t fold_message_bytes(input crc_t crc_in, input logic [DATA_W-1:0] data,
                                                 input int nbytes, input logic wide);
        crc_t crc;
        crc_t poly;
        crc  = crc_in;
        poly = wide ? POLY_64 : POLY_32;
        for (int i = 0; i < nbytes; i++) begin
            crc ^= crc_t'(data[i*8 +: 8]);
            for (int b = 0; b < 8; b++) begin
                crc = (crc >> 1) ^ (crc[0] ? poly : '0);
            end
        end
        return crc;
    endfunction

    task automatic report_mismatch(input string what, input crc_t got, input crc_t want);
        // keep the log short if everything goes wrong
        if (mismatches < 100) begin
            $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        crc_t mask;
        crc_t crc;
        int   nbytes;
        if (!aresetn) begin
            wide_mode   = 1'b0;
            seed_reg    = '0;
            running_crc = '1;
            expected_crcs.delete();
            mismatches  = 0;
            crc_pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE: wide_mode = cfg_data[0];
                    CFG_SEED: seed_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_crcs.size() == 0) begin
                    report_mismatch("unexpected crc_result", m_crc_result, '0);
                end else begin
                    crc = expected_crcs.pop_front();
                    if (m_crc_result !== crc) begin
                        report_mismatch("crc_result", m_crc_result, crc);
                    end
                end
            end
            if (s_valid && s_ready) begin
                mask   = wide_mode ? '1 : MASK_32;
                nbytes = (s_byte_count > LANE_COUNT) ? LANE_COUNT : int'(s_byte_count);
                crc    = s_start_message ? (~seed_reg & mask) : (running_crc & mask);
                running_crc = fold_message_bytes(crc, s_data_bytes, nbytes, wide_mode) & mask;
                expected_crcs.push_back(~running_crc & mask);
            end
            crc_pending = expected_crcs.size();
        end
    end

endmodule

### test/tb.sv
// top of the crc engine test: clock, reset, request and config stimulus, verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crceng_pkg::*;

    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all before giving up
    localparam int LONG_HOLD     = 300;   // receiver hold-off that backs up the pipeline
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 115;
    // "12345678" with the first character in the low byte
    localparam logic [DATA_W-1:0] CHECK_BYTES = 64'h3837_3635_3433_3231;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CRC_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_start_message;
    logic [DATA_W-1:0]    s_data_bytes;
    logic [COUNT_W-1:0]   s_byte_count;
    logic                 m_valid;
    logic                 m_ready;
    logic [CRC_W-1:0]     m_crc_result;

    int mismatches;
    int crc_pending;

    // handshakes seen at the last rising edge, read by the drivers at the falling edge
    logic s_taken   = 1'b0;
    logic m_taken   = 1'b0;
    logic cfg_taken = 1'b0;
    int   idle_cycles = 0;

    // idling knobs shared between the request driver and the result receiver
    bit tx_idle;
    bit rx_idle;
    bit rx_hold_req;

    crc32_crc64_reflected_engine DUT (.*);
    crc_checker u_checker (.*);

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        s_taken   <= (s_valid && s_ready) === 1'b1;
        m_taken   <= (m_valid && m_ready) === 1'b1;
        cfg_taken <= (cfg_valid && cfg_ready) === 1'b1;
    end

    // watchdog: the run is stuck if no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) === 1'b1 || (m_valid && m_ready) === 1'b1
                || (cfg_valid && cfg_ready) === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly zero, some short gaps and a few long ones
    function automatic int gap_cycles(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly legal counts, the rest anywhere in the field including zero and above eight
    function automatic logic [COUNT_W-1:0] random_count();
        if ($urandom_range(0, 19) < 15) return COUNT_W'($urandom_range(1, 8));
        return COUNT_W'($urandom_range(0, 15));
    endfunction

    // seeds: the two extremes now and then, otherwise random
    function automatic crc_t random_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return rand64();
    endfunction

    // result side: random ready pattern, plus one long hold-off on request
    initial begin
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
            n = gap_cycles(rx_idle);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_request(input bit start, input logic [DATA_W-1:0] data,
                                input logic [COUNT_W-1:0] count);
        int n;
        n = gap_cycles(tx_idle);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_start_message <= start;
        s_data_bytes    <= data;
        s_byte_count    <= count;
        do @(negedge aclk); while (!s_taken);
    endtask

    // stop offering requests and wait until every result is back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (crc_pending != 0);
    endtask

    // only called with nothing in flight
    task automatic write_register(input cfg_idx_t idx, input crc_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int  sent;
        int  msg_len;
        bit  start;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_MODE;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_start_message = 1'b0;
        s_data_bytes    = '0;
        s_byte_count    = '0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        rx_hold_req     = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        // crc-32, zero seed, check string split over two requests
        write_register(CFG_MODE, '0);
        write_register(CFG_SEED, '0);
        send_request(1'b1, CHECK_BYTES, 4'd8);
        send_request(1'b0, 64'h39, 4'd1);
        // zero byte count: with reload and without
        send_request(1'b1, '0, 4'd0);
        send_request(1'b0, '1, 4'd0);
        // counts above eight clamp to eight
        send_request(1'b0, '1, 4'd15);
        send_request(1'b0, rand64(), 4'd9);
        send_request(1'b0, '0, 4'd8);
        // every legal partial count
        for (int c = 1; c < 8; c++) begin
            send_request(1'b0, rand64(), COUNT_W'(c));
        end
        wait_all_results();

        // upper half of the seed must not matter in 32-bit mode
        write_register(CFG_SEED, 64'hFFFF_FFFF_0000_0000);
        send_request(1'b1, CHECK_BYTES, 4'd8);
        wait_all_results();

        // switch to crc-64 in the middle of a message, the running value carries over
        write_register(CFG_MODE, 64'd1);
        send_request(1'b0, 64'h39, 4'd1);
        wait_all_results();

        // crc-64 with the all-ones seed
        write_register(CFG_SEED, '1);
        send_request(1'b1, CHECK_BYTES, 4'd8);
        send_request(1'b0, 64'h39, 4'd1);
        send_request(1'b1, '1, 4'd8);
        wait_all_results();

        // back to crc-32 mid-message: upper half of the running value is dropped
        write_register(CFG_MODE, '0);
        send_request(1'b0, rand64(), 4'd5);
        wait_all_results();
        write_register(CFG_MODE, 64'd1);
        send_request(1'b0, rand64(), 4'd3);
        send_request(1'b1, '0, 4'd0);

        // ---- random part: phases of messages under different configs and idling ----
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_all_results();
            // some phases run without idling on one side, phase 7 on neither
            tx_idle = !(phase % 3 == 1 || phase == 7);
            rx_idle = !(phase % 4 == 2 || phase == 7);
            if (phase < 2 || $urandom_range(0, 1)) begin
                write_register(CFG_MODE, crc_t'($urandom_range(0, 1)));
            end
            write_register(CFG_SEED, random_seed());
            // backpressure phase: receiver holds off while requests keep coming
            if (phase == 5) begin
                tx_idle     = 1'b0;
                rx_hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                msg_len = $urandom_range(1, 8);
                for (int k = 0; k < msg_len; k++) begin
                    // messages mostly open with a reload; a stray reload now and then
                    if (k == 0) start = $urandom_range(0, 9) != 0;
                    else        start = $urandom_range(0, 29) == 0;
                    send_request(start, rand64(), random_count());
                    sent++;
                end
            end
        end

        wait_all_results();
        // leave room for any stray result after the last one
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
